[rtl/core/stb_pkg.sv]
// shared constants for the software timer bank
// slot count, time width, command and result codes
// no dependencies
package stb_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int TIME_BITS   = 48;

  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int PERIOD_W = 16;

  localparam int US_PER_MS   = 1000;
  localparam int MS_W        = 10;
  localparam int DELTA_W     = VALUE_W + MS_W;
  localparam int SUM_W       = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;
  localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd54925;

  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INTERVAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HANDLER  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_START    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd7;

  localparam logic [KIND_W-1:0] KIND_REPLY     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;

endpackage

[rtl/core/stb_ram.sv]
// generic single write port ram with registered read
// no dependencies
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/software_timer_bank_core.sv]
// software timer bank core: tick driven slot scan and slot commands; uses stb_pkg and stb_ram
// command reply strobed in the cycle after the transfer; allocate reply after a search of
//   the used flags, one slot per cycle
// tick: busy during a scan of all slots, one slot per cycle through ram read, x1000 and
//   compare; at most one result per cycle, strobed and never held off by the receiver
// reset clears time, sequencer and used, periodic and handler flags, sets stop flags and period 54925; rams not cleared
module software_timer_bank_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [stb_pkg::MODE_W-1:0]        mode_i,
  input  logic [stb_pkg::SLOT_W-1:0]        slot_i,
  input  logic [stb_pkg::VALUE_W-1:0]       value_i,
  input  logic                              cfg_we_i,
  input  logic [stb_pkg::PERIOD_W-1:0]      cfg_wdata_i,
  output logic                              strobe_o,
  output logic [stb_pkg::SLOT_W-1:0]        slot_out_o,
  output logic [stb_pkg::KIND_W-1:0]        kind_o,
  output logic                              ok_o,
  output logic                              last_o
);

  localparam int Slots  = stb_pkg::TIMER_SLOTS;
  localparam int TimeW  = stb_pkg::TIME_BITS;
  localparam int IdxW   = stb_pkg::IDX_W;
  localparam int CntW   = stb_pkg::CNT_W;
  localparam int SlotW  = stb_pkg::SLOT_W;
  localparam int ValW   = stb_pkg::VALUE_W;
  localparam int DeltaW = stb_pkg::DELTA_W;
  localparam int SumW   = stb_pkg::SUM_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_ALLOC = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [ValW-1:0]              val_q, val_d;
  logic [TimeW-1:0]             time_q, time_d;
  logic [stb_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [Slots-1:0]             used_q, used_d;
  logic [Slots-1:0]             stop_q, stop_d;
  logic [Slots-1:0]             per_q, per_d;
  logic [Slots-1:0]             hdl_q, hdl_d;

  logic                         s1_vld_q, s1_vld_d;
  logic [IdxW-1:0]              s1_idx_q;
  logic                         s2_vld_q;
  logic [IdxW-1:0]              s2_idx_q;
  logic [DeltaW-1:0]            prod_q;
  logic [TimeW-1:0]             start2_q;

  logic                         pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]              pend_idx_q, pend_idx_d;

  logic                         res_vld_q, res_vld_d;
  logic [SlotW-1:0]             res_slot_q, res_slot_d;
  logic [stb_pkg::KIND_W-1:0]   res_kind_q, res_kind_d;
  logic                         res_ok_q, res_ok_d;
  logic                         res_last_q, res_last_d;

  logic                         st_we, iv_we;
  logic [IdxW-1:0]              st_waddr, iv_waddr, ram_raddr;
  logic [TimeW-1:0]             st_wdata, st_rdata;
  logic [ValW-1:0]              iv_wdata, iv_rdata;

  logic                         accept;
  logic [TimeW:0]               time_sum;
  logic [IdxW-1:0]              cmd_idx, cnt_idx;
  logic                         cmd_hit;
  logic [SumW-1:0]              deadline;
  logic                         expired;

  stb_ram #(.WIDTH(TimeW), .DEPTH(Slots)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (st_rdata)
  );

  stb_ram #(.WIDTH(ValW), .DEPTH(Slots)) u_interval_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (iv_waddr),
    .wdata_i (iv_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (iv_rdata)
  );

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign cnt_idx   = cnt_q[IdxW-1:0];
  assign ram_raddr = cnt_idx;
  assign cmd_idx   = IdxW'(slot_i);
  assign cmd_hit   = (32'(slot_i) < 32'(Slots)) && used_q[cmd_idx];
  assign time_sum  = {1'b0, time_q} + (TimeW + 1)'(period_q);
  assign deadline  = SumW'(start2_q) + SumW'(prod_q);
  assign expired   = s2_vld_q && used_q[s2_idx_q] && !stop_q[s2_idx_q] && hdl_q[s2_idx_q]
                     && (SumW'(time_q) >= deadline);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    time_d     = time_q;
    period_d   = cfg_we_i ? cfg_wdata_i : period_q;
    used_d     = used_q;
    stop_d     = stop_q;
    per_d      = per_q;
    hdl_d      = hdl_q;
    s1_vld_d   = 1'b0;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    res_vld_d  = 1'b0;
    res_slot_d = res_slot_q;
    res_kind_d = res_kind_q;
    res_ok_d   = res_ok_q;
    res_last_d = res_last_q;
    st_we      = 1'b0;
    st_waddr   = cmd_idx;
    st_wdata   = time_q;
    iv_we      = 1'b0;
    iv_waddr   = cmd_idx;
    iv_wdata   = value_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            stb_pkg::MODE_TICK: begin
              time_d  = time_sum[TimeW] ? {TimeW{1'b1}} : time_sum[TimeW-1:0];
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            stb_pkg::MODE_ALLOC: begin
              val_d   = value_i;
              cnt_d   = '0;
              state_d = ST_ALLOC;
            end
            default: begin
              res_vld_d  = 1'b1;
              res_slot_d = slot_i;
              res_kind_d = stb_pkg::KIND_REPLY;
              res_ok_d   = cmd_hit;
              res_last_d = 1'b1;
              if (cmd_hit) begin
                case (mode_i)
                  stb_pkg::MODE_FREE: begin
                    used_d[cmd_idx] = 1'b0;
                    stop_d[cmd_idx] = 1'b1;
                    per_d[cmd_idx]  = 1'b0;
                    hdl_d[cmd_idx]  = 1'b0;
                  end
                  stb_pkg::MODE_INTERVAL: iv_we = 1'b1;
                  stb_pkg::MODE_HANDLER:  hdl_d[cmd_idx] = value_i[0];
                  stb_pkg::MODE_STOP:     stop_d[cmd_idx] = 1'b1;
                  stb_pkg::MODE_START: begin
                    stop_d[cmd_idx] = 1'b0;
                    st_we           = 1'b1;
                  end
                  default:                per_d[cmd_idx] = value_i[0];
                endcase
              end
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (!used_q[cnt_idx]) begin
          used_d[cnt_idx] = 1'b1;
          stop_d[cnt_idx] = 1'b1;
          per_d[cnt_idx]  = 1'b0;
          hdl_d[cnt_idx]  = 1'b0;
          iv_we           = 1'b1;
          iv_waddr        = cnt_idx;
          iv_wdata        = val_q;
          res_vld_d       = 1'b1;
          res_slot_d      = SlotW'(cnt_idx);
          res_kind_d      = stb_pkg::KIND_REPLY;
          res_ok_d        = 1'b1;
          res_last_d      = 1'b1;
          state_d         = ST_IDLE;
        end else if (cnt_q == CntW'(Slots - 1)) begin
          res_vld_d  = 1'b1;
          res_slot_d = '0;
          res_kind_d = stb_pkg::KIND_REPLY;
          res_ok_d   = 1'b0;
          res_last_d = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCAN: begin
        if (cnt_q < CntW'(Slots)) begin
          s1_vld_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
        if (expired) begin
          if (per_q[s2_idx_q]) begin
            st_we    = 1'b1;
            st_waddr = s2_idx_q;
          end else begin
            stop_d[s2_idx_q] = 1'b1;
          end
          if (pend_vld_q) begin
            res_vld_d  = 1'b1;
            res_slot_d = SlotW'(pend_idx_q);
            res_kind_d = stb_pkg::KIND_EXPIRY;
            res_ok_d   = 1'b1;
            res_last_d = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_idx_d = s2_idx_q;
        end
        if (s2_vld_q && (s2_idx_q == IdxW'(Slots - 1))) begin
          state_d = ST_FIN;
        end
      end
      default: begin
        res_vld_d  = 1'b1;
        res_slot_d = pend_vld_q ? SlotW'(pend_idx_q) : '0;
        res_kind_d = pend_vld_q ? stb_pkg::KIND_EXPIRY : stb_pkg::KIND_IDLE_TICK;
        res_ok_d   = 1'b1;
        res_last_d = 1'b1;
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      time_q     <= '0;
      period_q   <= stb_pkg::PERIOD_RESET;
      used_q     <= '0;
      stop_q     <= '1;
      per_q      <= '0;
      hdl_q      <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      time_q     <= time_d;
      period_q   <= period_d;
      used_q     <= used_d;
      stop_q     <= stop_d;
      per_q      <= per_d;
      hdl_q      <= hdl_d;
      s1_vld_q   <= s1_vld_d;
      s2_vld_q   <= s1_vld_q;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // scan pipeline, allocate value and result payload
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    s1_idx_q   <= cnt_idx;
    s2_idx_q   <= s1_idx_q;
    prod_q     <= DeltaW'(iv_rdata) * DeltaW'(stb_pkg::US_PER_MS);
    start2_q   <= st_rdata;
    pend_idx_q <= pend_idx_d;
    res_slot_q <= res_slot_d;
    res_kind_q <= res_kind_d;
    res_ok_q   <= res_ok_d;
    res_last_q <= res_last_d;
  end

  assign strobe_o   = res_vld_q;
  assign slot_out_o = res_slot_q;
  assign kind_o     = res_kind_q;
  assign ok_o       = res_ok_q;
  assign last_o     = res_last_q;

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == stb_pkg::MODE_TICK) |=> busy)
    else $error("tick transfer did not start a scan");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_vld_q)
    else $error("expiry left pending while idle");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> time_q >= $past(time_q))
    else $error("running time went backward");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (kind_o == stb_pkg::KIND_IDLE_TICK) |-> last_o && (slot_out_o == '0))
    else $error("malformed tick result without expiry");

endmodule
